>>> sv/resistive_touch_point_processor_macros.svh
// Assertion helpers for the touch point processor
`ifndef RESISTIVE_TOUCH_POINT_PROCESSOR_MACROS_SVH
`define RESISTIVE_TOUCH_POINT_PROCESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TPP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpp check failed");

// Implication across the full pipeline latency
`define TPP_ASSERT_LAT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      (ante) |-> ##(tpp_pkg::LATENCY) (cons)) else $error("tpp latency check failed");

`endif

>>> sv/tpp_pkg.sv
package tpp_pkg;

   localparam int ADC_BITS    = 12;
   localparam int SAMPLE_W    = 12;
   localparam logic [SAMPLE_W-1:0] ADC_MAX = SAMPLE_W'((1 << ADC_BITS) - 1);
   localparam int GRID_POINTS = 4;

   localparam int DIV_W      = 28;   // dividend / quotient width
   localparam int DEN_W      = 12;   // divisor width
   localparam int DIV_STAGES = DIV_W;
   localparam int LATENCY    = DIV_STAGES + 7;

   // x/15 as (x * RECIP_15) >> RECIP_SHIFT, exact for x < 2^20
   localparam logic [19:0] RECIP_15    = 20'h88889;
   localparam int          RECIP_SHIFT = 23;

   localparam logic [2:0] REG_NOISE  = 3'd0;
   localparam logic [2:0] REG_OHMS   = 3'd1;
   localparam logic [2:0] REG_XEXT   = 3'd2;
   localparam logic [2:0] REG_YEXT   = 3'd3;
   localparam logic [2:0] REG_XTABLE = 3'd4;
   localparam logic [2:0] REG_YTABLE = 3'd5;

   typedef struct packed {
      logic [11:0] in0;
      logic [11:0] in1;
      logic [3:0]  f0;
      logic [3:0]  f1;
   } seg_type;

   typedef struct packed {
      logic             ok;
      logic [1:0]       neg;
      logic [1:0]       dvz;
      logic [1:0][15:0] o0;
      logic             nonpos;
      logic             z1z;
      logic [12:0]      simple;
   } side_type;

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [11:0] v);
      return (v > ADC_MAX) ? ADC_MAX : v;
   endfunction

   function automatic logic [15:0] grid_word(input logic [63:0] tab, input logic [1:0] k);
      return tab[16*k +: 16];
   endfunction

   // first segment i with raw >= breakpoint[i+1], clamped to the last pair
   function automatic seg_type grid_select(input logic [11:0] raw, input logic [63:0] tab);
      seg_type   s;
      logic [1:0] seg;
      logic [15:0] w0, w1;
      seg = 2'(GRID_POINTS - 2);
      for (int k = GRID_POINTS - 3; k >= 0; k--) begin
         if (raw >= grid_word(tab, 2'(k + 1)) >> 4)
            seg = 2'(k);
      end
      w0 = grid_word(tab, seg);
      w1 = grid_word(tab, 2'(seg + 2'd1));
      s.in0 = w0[15:4];
      s.in1 = w1[15:4];
      s.f0  = w0[3:0];
      s.f1  = w1[3:0];
      return s;
   endfunction

endpackage

>>> sv/tpp_div.sv
// Pipelined restoring divider, one quotient bit per stage
module tpp_div (
   input  logic                       clock,
   input  logic [tpp_pkg::DIV_W-1:0]  dividend,
   input  logic [tpp_pkg::DEN_W-1:0]  divisor,
   output logic [tpp_pkg::DIV_W-1:0]  quotient
);

   // work holds unused dividend bits on top, quotient bits shifting in below
   logic [tpp_pkg::DIV_W-1:0] work_ff [tpp_pkg::DIV_STAGES];
   logic [tpp_pkg::DEN_W-1:0] rem_ff  [tpp_pkg::DIV_STAGES];
   logic [tpp_pkg::DEN_W-1:0] den_ff  [tpp_pkg::DIV_STAGES];

   for (genvar s = 0; s < tpp_pkg::DIV_STAGES; s++) begin : g_stage
      logic [tpp_pkg::DIV_W-1:0] work_prev;
      logic [tpp_pkg::DEN_W-1:0] rem_prev, den_prev;
      logic [tpp_pkg::DEN_W:0]   trial, diff;
      logic                      qbit;

      if (s == 0) begin : g_first
         assign work_prev = dividend;
         assign rem_prev  = '0;
         assign den_prev  = divisor;
      end else begin : g_next
         assign work_prev = work_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
      end

      assign trial = {rem_prev, work_prev[tpp_pkg::DIV_W-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign qbit  = (trial >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         work_ff[s] <= {work_prev[tpp_pkg::DIV_W-2:0], qbit};
         rem_ff[s]  <= qbit ? diff[tpp_pkg::DEN_W-1:0] : trial[tpp_pkg::DEN_W-1:0];
         den_ff[s]  <= den_prev;
      end
   end

   assign quotient = work_ff[tpp_pkg::DIV_STAGES-1];

endmodule

>>> sv/resistive_touch_point_processor.sv
// Throughput: one transaction per cycle; busy is never raised.
// The path runs through six preprocessing stages and then the 28-stage
// divider pipelines; one output register closes the path.
// Reset is synchronous, active high: clears all valid bits and loads the
// register defaults; results in flight are dropped.
`include "resistive_touch_point_processor_macros.svh"

module resistive_touch_point_processor (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_x_sample_first,
   input  logic [11:0] req_x_sample_second,
   input  logic [11:0] req_y_sample_first,
   input  logic [11:0] req_y_sample_second,
   input  logic [11:0] req_pressure_low_sample,
   input  logic [11:0] req_pressure_high_sample,
   output logic        rsp_valid,
   output logic [15:0] rsp_x_position,
   output logic [15:0] rsp_y_position,
   output logic [15:0] rsp_touch_pressure,
   output logic        rsp_point_valid,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // ---------------- configuration ----------------
   logic [11:0] noise_ff;
   logic [15:0] ohms_ff;
   logic [15:0] ext_ff [2];
   logic [63:0] tab_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff  <= 12'd100;
         ohms_ff   <= 16'd0;
         ext_ff[0] <= 16'd240;
         ext_ff[1] <= 16'd320;
         tab_ff[0] <= 64'h0000_5555_AAAA_FFFF;
         tab_ff[1] <= 64'h0000_5555_AAAA_FFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            tpp_pkg::REG_NOISE:  noise_ff  <= csr_wdata[11:0];
            tpp_pkg::REG_OHMS:   ohms_ff   <= csr_wdata[15:0];
            tpp_pkg::REG_XEXT:   ext_ff[0] <= csr_wdata[15:0];
            tpp_pkg::REG_YEXT:   ext_ff[1] <= csr_wdata[15:0];
            tpp_pkg::REG_XTABLE: tab_ff[0] <= csr_wdata;
            tpp_pkg::REG_YTABLE: tab_ff[1] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- valid chain ----------------
   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff, vld_f_ff;
   logic vld_s_ff [tpp_pkg::DIV_STAGES];
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff     <= 1'b0;
         vld_b_ff     <= 1'b0;
         vld_c_ff     <= 1'b0;
         vld_d_ff     <= 1'b0;
         vld_e_ff     <= 1'b0;
         vld_f_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tpp_pkg::DIV_STAGES; i++)
            vld_s_ff[i] <= 1'b0;
      end else begin
         vld_a_ff     <= start && !busy;
         vld_b_ff     <= vld_a_ff;
         vld_c_ff     <= vld_b_ff;
         vld_d_ff     <= vld_c_ff;
         vld_e_ff     <= vld_d_ff;
         vld_f_ff     <= vld_e_ff;
         vld_s_ff[0]  <= vld_f_ff;
         for (int i = 1; i < tpp_pkg::DIV_STAGES; i++)
            vld_s_ff[i] <= vld_s_ff[i-1];
         rsp_valid_ff <= vld_s_ff[tpp_pkg::DIV_STAGES-1];
      end
   end

   // ---------------- stage A: noise check, average, invert ----------------
   logic [11:0] s_first [2];
   logic [11:0] s_second [2];
   logic [11:0] raw_a_in [2];
   logic [1:0]  good_a_in;
   logic [11:0] raw_a_ff [2];
   logic        ok_a_ff;
   logic [11:0] z1_a_ff, z2_a_ff;

   assign s_first[0]  = tpp_pkg::clamp_sample(req_x_sample_first);
   assign s_second[0] = tpp_pkg::clamp_sample(req_x_sample_second);
   assign s_first[1]  = tpp_pkg::clamp_sample(req_y_sample_first);
   assign s_second[1] = tpp_pkg::clamp_sample(req_y_sample_second);

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_a
      logic [11:0] diff, pick;
      logic [12:0] sum;
      assign diff = (s_first[ax] >= s_second[ax]) ? s_first[ax] - s_second[ax]
                                                  : s_second[ax] - s_first[ax];
      assign sum  = {1'b0, s_first[ax]} + {1'b0, s_second[ax]};
      assign good_a_in[ax] = (diff <= noise_ff);
      assign pick = good_a_in[ax] ? sum[12:1] : s_second[ax];
      assign raw_a_in[ax] = tpp_pkg::ADC_MAX - pick;
   end

   always_ff @(posedge clock) begin
      raw_a_ff[0] <= raw_a_in[0];
      raw_a_ff[1] <= raw_a_in[1];
      ok_a_ff     <= &good_a_in;
      z1_a_ff     <= tpp_pkg::clamp_sample(req_pressure_low_sample);
      z2_a_ff     <= tpp_pkg::clamp_sample(req_pressure_high_sample);
   end

   // ---------------- stage B: segment select, scale outputs ----------------
   logic [11:0] raw_b_ff [2];
   logic [11:0] in0_b_ff [2];
   logic [11:0] in1_b_ff [2];
   logic [19:0] fe0_b_ff [2];
   logic [19:0] fe1_b_ff [2];
   logic signed [25:0] pz_b_ff;
   logic [11:0] z1_b_ff;
   logic [12:0] simple_b_ff;
   logic        ok_b_ff;
   logic signed [12:0] dz_b;
   logic signed [13:0] simple_b;

   assign dz_b     = $signed({1'b0, z2_a_ff}) - $signed({1'b0, z1_a_ff});
   assign simple_b = $signed({2'b00, tpp_pkg::ADC_MAX}) - 14'(dz_b);

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_b
      tpp_pkg::seg_type seg;
      assign seg = tpp_pkg::grid_select(raw_a_ff[ax], tab_ff[ax]);
      always_ff @(posedge clock) begin
         raw_b_ff[ax] <= raw_a_ff[ax];
         in0_b_ff[ax] <= seg.in0;
         in1_b_ff[ax] <= seg.in1;
         fe0_b_ff[ax] <= 20'(seg.f0) * 20'(ext_ff[ax]);
         fe1_b_ff[ax] <= 20'(seg.f1) * 20'(ext_ff[ax]);
      end
   end

   always_ff @(posedge clock) begin
      pz_b_ff     <= 26'(dz_b) * $signed({14'd0, raw_a_ff[0]});
      z1_b_ff     <= z1_a_ff;
      simple_b_ff <= simple_b[12:0];
      ok_b_ff     <= ok_a_ff;
   end

   // ---------------- stage C: divide outputs by 15, pressure product ----------------
   logic [11:0] raw_c_ff [2];
   logic [11:0] in0_c_ff [2];
   logic [11:0] in1_c_ff [2];
   logic [15:0] o0_c_ff [2];
   logic [15:0] o1_c_ff [2];
   logic signed [42:0] pn_c_ff;
   logic [11:0] z1_c_ff;
   logic [12:0] simple_c_ff;
   logic        ok_c_ff;

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_c
      logic [39:0] q0, q1;
      assign q0 = 40'(fe0_b_ff[ax]) * 40'(tpp_pkg::RECIP_15);
      assign q1 = 40'(fe1_b_ff[ax]) * 40'(tpp_pkg::RECIP_15);
      always_ff @(posedge clock) begin
         raw_c_ff[ax] <= raw_b_ff[ax];
         in0_c_ff[ax] <= in0_b_ff[ax];
         in1_c_ff[ax] <= in1_b_ff[ax];
         o0_c_ff[ax]  <= q0[tpp_pkg::RECIP_SHIFT +: 16];
         o1_c_ff[ax]  <= q1[tpp_pkg::RECIP_SHIFT +: 16];
      end
   end

   always_ff @(posedge clock) begin
      pn_c_ff     <= 43'(pz_b_ff) * $signed({27'd0, ohms_ff});
      z1_c_ff     <= z1_b_ff;
      simple_c_ff <= simple_b_ff;
      ok_c_ff     <= ok_b_ff;
   end

   // ---------------- stage D: differences ----------------
   logic signed [12:0] dn_d_ff [2];
   logic signed [16:0] do_d_ff [2];
   logic signed [12:0] dv_d_ff [2];
   logic [15:0] o0_d_ff [2];
   logic [27:0] pdv_d_ff;
   logic        nonpos_d_ff;
   logic [11:0] z1_d_ff;
   logic [12:0] simple_d_ff;
   logic        ok_d_ff;

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_d
      always_ff @(posedge clock) begin
         dn_d_ff[ax] <= $signed({1'b0, raw_c_ff[ax]}) - $signed({1'b0, in0_c_ff[ax]});
         do_d_ff[ax] <= $signed({1'b0, o1_c_ff[ax]}) - $signed({1'b0, o0_c_ff[ax]});
         dv_d_ff[ax] <= $signed({1'b0, in1_c_ff[ax]}) - $signed({1'b0, in0_c_ff[ax]});
         o0_d_ff[ax] <= o0_c_ff[ax];
      end
   end

   // den is z1 * 2^ADC_BITS, so drop those bits from the numerator first
   always_ff @(posedge clock) begin
      pdv_d_ff    <= pn_c_ff[tpp_pkg::ADC_BITS +: tpp_pkg::DIV_W];
      nonpos_d_ff <= (pn_c_ff <= 43'sd0);
      z1_d_ff     <= z1_c_ff;
      simple_d_ff <= simple_c_ff;
      ok_d_ff     <= ok_c_ff;
   end

   // ---------------- stage E: slope product ----------------
   logic signed [29:0] prod_e_ff [2];
   logic signed [12:0] dv_e_ff [2];
   logic [15:0] o0_e_ff [2];
   logic [27:0] pdv_e_ff;
   logic        nonpos_e_ff;
   logic [11:0] z1_e_ff;
   logic [12:0] simple_e_ff;
   logic        ok_e_ff;

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_e
      always_ff @(posedge clock) begin
         prod_e_ff[ax] <= 30'(dn_d_ff[ax]) * 30'(do_d_ff[ax]);
         dv_e_ff[ax]   <= dv_d_ff[ax];
         o0_e_ff[ax]   <= o0_d_ff[ax];
      end
   end

   always_ff @(posedge clock) begin
      pdv_e_ff    <= pdv_d_ff;
      nonpos_e_ff <= nonpos_d_ff;
      z1_e_ff     <= z1_d_ff;
      simple_e_ff <= simple_d_ff;
      ok_e_ff     <= ok_d_ff;
   end

   // ---------------- stage F: magnitudes into the dividers ----------------
   logic [27:0] mag_f_ff [2];
   logic [11:0] dvm_f_ff [2];
   logic [27:0] pdv_f_ff;
   logic [11:0] z1_f_ff;
   tpp_pkg::side_type side_f_ff;

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_f
      logic signed [29:0] pabs;
      logic signed [12:0] dabs;
      assign pabs = prod_e_ff[ax][29] ? -prod_e_ff[ax] : prod_e_ff[ax];
      assign dabs = dv_e_ff[ax][12] ? -dv_e_ff[ax] : dv_e_ff[ax];
      always_ff @(posedge clock) begin
         mag_f_ff[ax] <= pabs[27:0];
         dvm_f_ff[ax] <= dabs[11:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int ax = 0; ax < 2; ax++) begin
         side_f_ff.neg[ax] <= prod_e_ff[ax][29] ^ dv_e_ff[ax][12];
         side_f_ff.dvz[ax] <= (dv_e_ff[ax] == 13'sd0);
         side_f_ff.o0[ax]  <= o0_e_ff[ax];
      end
      pdv_f_ff         <= pdv_e_ff;
      z1_f_ff          <= z1_e_ff;
      side_f_ff.ok     <= ok_e_ff;
      side_f_ff.nonpos <= nonpos_e_ff;
      side_f_ff.z1z    <= (z1_e_ff == 12'd0);
      side_f_ff.simple <= simple_e_ff;
   end

   // ---------------- dividers and sideband delay ----------------
   logic [27:0] quo [2];
   logic [27:0] pquo;
   tpp_pkg::side_type side_s_ff [tpp_pkg::DIV_STAGES];

   tpp_div u_div_x (.clock(clock), .dividend(mag_f_ff[0]), .divisor(dvm_f_ff[0]),
                    .quotient(quo[0]));
   tpp_div u_div_y (.clock(clock), .dividend(mag_f_ff[1]), .divisor(dvm_f_ff[1]),
                    .quotient(quo[1]));
   tpp_div u_div_p (.clock(clock), .dividend(pdv_f_ff), .divisor(z1_f_ff),
                    .quotient(pquo));

   always_ff @(posedge clock) begin
      side_s_ff[0] <= side_f_ff;
      for (int i = 1; i < tpp_pkg::DIV_STAGES; i++)
         side_s_ff[i] <= side_s_ff[i-1];
   end

   // ---------------- stage G: sign, offset, saturate ----------------
   tpp_pkg::side_type side_g;
   logic [15:0] pos_g [2];
   logic [15:0] press_g;
   logic [15:0] x_pos_ff, y_pos_ff, press_ff;
   logic        pvalid_ff;

   assign side_g = side_s_ff[tpp_pkg::DIV_STAGES-1];

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis_g
      logic signed [30:0] qs, pos;
      assign qs  = side_g.neg[ax] ? -$signed({3'b000, quo[ax]}) : $signed({3'b000, quo[ax]});
      assign pos = side_g.dvz[ax] ? $signed({15'd0, side_g.o0[ax]})
                                  : qs + $signed({15'd0, side_g.o0[ax]});
      always_comb begin
         if (pos < 31'sd0)
            pos_g[ax] = 16'd0;
         else if (pos > $signed({15'd0, ext_ff[ax]}))
            pos_g[ax] = ext_ff[ax];
         else
            pos_g[ax] = pos[15:0];
      end
   end

   always_comb begin
      if (!side_g.ok)
         press_g = 16'd0;
      else if (ohms_ff == 16'd0)
         press_g = 16'(side_g.simple);
      else if (side_g.z1z)
         press_g = 16'hFFFF;
      else if (side_g.nonpos)
         press_g = 16'd0;
      else if (pquo[27:16] != 12'd0)
         press_g = 16'hFFFF;
      else
         press_g = pquo[15:0];
   end

   always_ff @(posedge clock) begin
      x_pos_ff  <= pos_g[0];
      y_pos_ff  <= pos_g[1];
      press_ff  <= press_g;
      pvalid_ff <= side_g.ok;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_x_position     = x_pos_ff;
   assign rsp_y_position     = y_pos_ff;
   assign rsp_touch_pressure = press_ff;
   assign rsp_point_valid    = pvalid_ff;

   // ---------------- checks ----------------
   `TPP_ASSERT_NOW(a_invalid_no_press, clock, reset, rsp_valid && !rsp_point_valid, rsp_touch_pressure == 16'd0)
   `TPP_ASSERT_NOW(a_x_in_range, clock, reset, rsp_valid, rsp_x_position <= ext_ff[0])
   `TPP_ASSERT_NOW(a_y_in_range, clock, reset, rsp_valid, rsp_y_position <= ext_ff[1])
   `TPP_ASSERT_LAT(a_latency, clock, reset, start && !busy, rsp_valid)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;
   localparam int PIPE_DEPTH = 35;

   typedef struct {
      logic [11:0] xa, xb, ya, yb, z1, z2;
   } touch_sample_type;

   typedef struct {
      logic [15:0] x_pos, y_pos, pressure;
      logic        valid;
   } touch_point_type;

   typedef struct {
      logic [11:0] xa, xb, ya, yb, z1, z2;
      bit          typed;
      logic [15:0] x_pos, y_pos, pressure;
      logic        valid;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_x_sample_first = '0, req_x_sample_second = '0;
   logic [11:0] req_y_sample_first = '0, req_y_sample_second = '0;
   logic [11:0] req_pressure_low_sample = '0, req_pressure_high_sample = '0;
   logic        rsp_valid;
   logic [15:0] rsp_x_position, rsp_y_position, rsp_touch_pressure;
   logic        rsp_point_valid;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // shadow copy of the block's registers
   logic [11:0] cfg_noise;
   logic [15:0] cfg_ohms, cfg_xext, cfg_yext;
   logic [63:0] cfg_xtab, cfg_ytab;

   touch_point_type pending_points[$];
   int              errors = 0;

   always #10 clock = ~clock;

   resistive_touch_point_processor u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_sample_first(req_x_sample_first),
      .req_x_sample_second(req_x_sample_second),
      .req_y_sample_first(req_y_sample_first),
      .req_y_sample_second(req_y_sample_second),
      .req_pressure_low_sample(req_pressure_low_sample),
      .req_pressure_high_sample(req_pressure_high_sample),
      .rsp_valid(rsp_valid), .rsp_x_position(rsp_x_position),
      .rsp_y_position(rsp_y_position), .rsp_touch_pressure(rsp_touch_pressure),
      .rsp_point_valid(rsp_point_valid),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task automatic report(input string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      errors++;
   endtask

   // averaged or second sample, inverted; clears ok on excess noise
   function automatic longint axis_level(input logic [11:0] a, input logic [11:0] b,
                                         inout bit ok);
      longint s0, s1, d;
      s0 = a;
      s1 = b;
      d  = (s0 > s1) ? s0 - s1 : s1 - s0;
      if (d > longint'(cfg_noise)) ok = 0;
      else s1 = (s0 + s1) >> 1;
      return longint'(tpp_pkg::ADC_MAX) - s1;
   endfunction

   function automatic logic [15:0] grid_map(input longint raw, input logic [63:0] tab,
                                            input longint ext);
      int     i;
      longint in0, in1, o0, o1, dv, pos;
      i = 0;
      while (i < tpp_pkg::GRID_POINTS - 2 && raw < longint'(tab[16*(i+1)+4 +: 12])) i++;
      in0 = tab[16*i+4 +: 12];
      in1 = tab[16*(i+1)+4 +: 12];
      o0  = longint'(tab[16*i +: 4]) * ext / 15;
      o1  = longint'(tab[16*(i+1) +: 4]) * ext / 15;
      dv  = in1 - in0;
      pos = (dv == 0) ? o0 : (raw - in0) * (o1 - o0) / dv + o0;
      if (pos < 0) pos = 0;
      if (pos > ext) pos = ext;
      return 16'(pos);
   endfunction

   function automatic touch_point_type predict_point(input touch_sample_type s);
      touch_point_type p;
      bit              ok;
      longint          xr, yr, z1, z2, v;
      ok = 1;
      xr = axis_level(s.xa, s.xb, ok);
      yr = axis_level(s.ya, s.yb, ok);
      z1 = s.z1;
      z2 = s.z2;
      p.x_pos = grid_map(xr, cfg_xtab, cfg_xext);
      p.y_pos = grid_map(yr, cfg_ytab, cfg_yext);
      if (cfg_ohms != 0) begin
         if (z1 == 0) v = 65535;
         else begin
            v = (z2 - z1) * xr * longint'(cfg_ohms);
            v = (v <= 0) ? 0 : v / (z1 * (longint'(tpp_pkg::ADC_MAX) + 1));
         end
      end else begin
         v = longint'(tpp_pkg::ADC_MAX) - (z2 - z1);
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      p.pressure = ok ? 16'(v) : 16'd0;
      p.valid    = ok;
      return p;
   endfunction

   task automatic drain_points();
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         tpp_pkg::REG_NOISE:  cfg_noise = data[11:0];
         tpp_pkg::REG_OHMS:   cfg_ohms  = data[15:0];
         tpp_pkg::REG_XEXT:   cfg_xext  = data[15:0];
         tpp_pkg::REG_YEXT:   cfg_yext  = data[15:0];
         tpp_pkg::REG_XTABLE: cfg_xtab  = data;
         tpp_pkg::REG_YTABLE: cfg_ytab  = data;
         default: ;
      endcase
   endtask

   // holds start high across back-to-back transactions
   task automatic send_sample(input touch_sample_type s, input int gap,
                              input bit typed, input touch_point_type given);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                    <= 1'b1;
      req_x_sample_first       <= s.xa;
      req_x_sample_second      <= s.xb;
      req_y_sample_first       <= s.ya;
      req_y_sample_second      <= s.yb;
      req_pressure_low_sample  <= s.z1;
      req_pressure_high_sample <= s.z2;
      do @(posedge clock); while (busy);
      pending_points.push_back(typed ? given : predict_point(s));
   endtask

   // descending breakpoints; sometimes duplicates for flat segments, sometimes a fully random table
   function automatic logic [63:0] grid_table();
      logic [11:0] bp[4];
      logic [11:0] t;
      logic [63:0] tab;
      for (int k = 0; k < 4; k++) bp[k] = 12'($urandom_range(0, 4095));
      for (int a = 0; a < 4; a++)
         for (int b = a + 1; b < 4; b++)
            if (bp[b] > bp[a]) begin
               t = bp[a]; bp[a] = bp[b]; bp[b] = t;
            end
      if ($urandom_range(0, 3) == 0) bp[$urandom_range(1, 3)] = bp[0];
      if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
      for (int k = 0; k < 4; k++) tab[16*k +: 16] = {bp[k], 4'($urandom)};
      return tab;
   endfunction

   function automatic logic [11:0] near_sample(input logic [11:0] a);
      int d, v;
      d = (cfg_noise > 12'd300) ? 300 : int'(cfg_noise);
      v = int'(a) + $urandom_range(0, 2 * d) - d;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   function automatic touch_sample_type random_sample();
      touch_sample_type s;
      s.xa = 12'($urandom);
      s.ya = 12'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         s.xb = near_sample(s.xa);
         s.yb = near_sample(s.ya);
      end else begin
         s.xb = 12'($urandom);
         s.yb = 12'($urandom);
      end
      s.z1 = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom);
      s.z2 = 12'($urandom);
      return s;
   endfunction

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
   endfunction

   always @(posedge clock) begin
      touch_point_type e;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            report("result transaction with nothing expected");
         end else begin
            e = pending_points.pop_front();
            if (rsp_x_position !== e.x_pos)
               report($sformatf("x_position %0d, expected %0d", rsp_x_position, e.x_pos));
            if (rsp_y_position !== e.y_pos)
               report($sformatf("y_position %0d, expected %0d", rsp_y_position, e.y_pos));
            if (rsp_touch_pressure !== e.pressure)
               report($sformatf("touch_pressure %0d, expected %0d",
                                rsp_touch_pressure, e.pressure));
            if (rsp_point_valid !== e.valid)
               report($sformatf("point_valid %0b, expected %0b", rsp_point_valid, e.valid));
         end
      end
   end

   initial begin
      #4ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      directed_row_type rows[11] = '{
         '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 1, 16'd0, 16'd0, 16'd4095, 1'b1},
         '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1, 16'd240, 16'd320, 16'd4095, 1'b1},
         // x samples far apart: invalid, pressure forced to zero
         '{12'd0, 12'd4095, 12'd0, 12'd0, 12'd7, 12'd9, 1, 16'd0, 16'd320, 16'd0, 1'b0},
         '{12'd0, 12'd0, 12'd4095, 12'd0, 12'd7, 12'd9, 0, '0, '0, '0, 1'b0},
         '{12'd1000, 12'd1100, 12'd2000, 12'd2100, 12'd100, 12'd200, 0, '0, '0, '0, 1'b0},
         '{12'd1000, 12'd1101, 12'd2000, 12'd2000, 12'd100, 12'd200, 0, '0, '0, '0, 1'b0},
         '{12'd1500, 12'd1500, 12'd2100, 12'd1999, 12'd100, 12'd200, 0, '0, '0, '0, 1'b0},
         '{12'd2730, 12'd2730, 12'd1365, 12'd1365, 12'd4095, 12'd0, 0, '0, '0, '0, 1'b0},
         '{12'd1365, 12'd1366, 12'd2731, 12'd2730, 12'd0, 12'd4095, 0, '0, '0, '0, 1'b0},
         '{12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'hFFF, 12'hFFF, 0, '0, '0, '0, 1'b0},
         '{12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA, 12'h555, 0, '0, '0, '0, 1'b0}
      };
      touch_sample_type s;
      touch_point_type  given;

      cfg_noise = 12'd100;
      cfg_ohms  = 16'd0;
      cfg_xext  = 16'd240;
      cfg_yext  = 16'd320;
      cfg_xtab  = 64'h00005555AAAAFFFF;
      cfg_ytab  = 64'h00005555AAAAFFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         s     = '{rows[r].xa, rows[r].xb, rows[r].ya, rows[r].yb, rows[r].z1, rows[r].z2};
         given = '{rows[r].x_pos, rows[r].y_pos, rows[r].pressure, rows[r].valid};
         send_sample(s, (r % 3 == 0) ? 0 : draw_gap(), rows[r].typed, given);
      end

      // phases of settings, extremes first
      for (int ph = 0; ph < 6; ph++) begin
         start <= 1'b0;
         drain_points();
         @(posedge clock);
         case (ph)
            0: begin
               write_reg(tpp_pkg::REG_NOISE, 64'd0);
               write_reg(tpp_pkg::REG_OHMS, 64'hFFFF);
               write_reg(tpp_pkg::REG_XEXT, 64'hFFFF);
               write_reg(tpp_pkg::REG_YEXT, 64'hFFFF);
               write_reg(tpp_pkg::REG_XTABLE, 64'hFFFF_FFFF_FFFF_FFFF);
               write_reg(tpp_pkg::REG_YTABLE, 64'hFFFF_AAA0_5550_000F);
            end
            1: begin
               write_reg(tpp_pkg::REG_NOISE, 64'hFFF);
               write_reg(tpp_pkg::REG_OHMS, 64'd1);
               write_reg(tpp_pkg::REG_XEXT, 64'd0);
               write_reg(tpp_pkg::REG_YEXT, 64'd1);
               write_reg(tpp_pkg::REG_XTABLE, 64'd0);
               write_reg(tpp_pkg::REG_YTABLE, grid_table());
               // writes to unused indexes must not disturb anything
               write_reg(REG_SPARE_A, {$urandom, $urandom});
               write_reg(REG_SPARE_B, {$urandom, $urandom});
            end
            default: begin
               write_reg(tpp_pkg::REG_NOISE, 64'($urandom_range(0, 400)));
               write_reg(tpp_pkg::REG_OHMS,
                         ($urandom_range(0, 2) == 0) ? 64'd0 : 64'(16'($urandom)));
               write_reg(tpp_pkg::REG_XEXT, 64'(16'($urandom)));
               write_reg(tpp_pkg::REG_YEXT, 64'($urandom_range(0, 1000)));
               write_reg(tpp_pkg::REG_XTABLE, grid_table());
               write_reg(tpp_pkg::REG_YTABLE, grid_table());
            end
         endcase
         csr_we <= 1'b0;
         for (int n = 0; n < 100; n++) begin
            given = '{'0, '0, '0, 1'b0};
            // stretches with no idling
            send_sample(random_sample(), (ph == 3 && n < 40) ? 0 : draw_gap(), 0, given);
         end
      end
      start <= 1'b0;

      drain_points();
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
